/* hdl/llkvm_pkg.sv */
// llkvm_pkg: transaction types and action codes for the linked list key-value map
// no dependencies; used by linked_list_key_value_map
package llkvm_pkg;

    localparam int FIELD_W = 32;
    localparam int COUNT_W = 8;

    // request action codes
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    // request transaction
    typedef struct packed {
        logic [1:0]                action;
        logic signed [FIELD_W-1:0] key;
        logic signed [FIELD_W-1:0] value;
    } t_req;

    // result transaction
    typedef struct packed {
        logic signed [FIELD_W-1:0] result_value;
        logic                      found;
        logic                      full_res;
        logic [COUNT_W-1:0]        entry_count;
    } t_resp;

endpackage

/* hdl/llkvm_ram.sv */
// llkvm_ram: generic single write port, single read port RAM with registered read
// no dependencies; instanced for the key, value and link stores
module llkvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/linked_list_key_value_map.sv */
// linked_list_key_value_map: fixed-capacity key-value map on a linked list of slots
// depends on llkvm_pkg and llkvm_ram (key, value and link stores)

// A request is taken when start is high and busy is low; busy then stays high until
// the result has been produced, but an unused action code never raises busy. The
// result appears on o_resp for exactly one cycle with o_strobe high and cannot be
// held off, so the receiver must take it then. A request is accepted, then the list
// nodes are compared (up to CAPACITY of them), then the result follows: a hit
// on search or add needs only the result cycle after the compare, remove passes
// through S_REM1 and S_REM2 to unlink the node and push its slot onto the free list,
// a miss passes through S_MISS, and an insert also through S_ALLOC to pop the free
// list. The single read port of the slot stores, one node per cycle, sets the pace of
// the walk. An unused action code is answered at once, without a walk. No clearing
// pass is needed after reset: slots never yet taken are tracked by a fill mark, so
// the block is ready as soon as reset ends.
module linked_list_key_value_map #(
    parameter int CAPACITY   = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  llkvm_pkg::t_req   i_req,
    output logic              busy,
    output logic              o_strobe,
    output llkvm_pkg::t_resp  o_resp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int XW = (DATA_WIDTH > llkvm_pkg::FIELD_W) ? DATA_WIDTH : llkvm_pkg::FIELD_W;
    localparam logic [PW-1:0] NIL      = PW'(CAPACITY);
    localparam logic [PW-1:0] LAST_IDX = PW'(CAPACITY - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMP   = 3'd1;
    localparam logic [2:0] S_REM1  = 3'd2;
    localparam logic [2:0] S_REM2  = 3'd3;
    localparam logic [2:0] S_MISS  = 3'd4;
    localparam logic [2:0] S_ALLOC = 3'd5;

    // control registers
    logic [2:0]  r_state, n_state;
    logic [PW-1:0] r_list_head, n_list_head;
    logic [PW-1:0] r_free_head, n_free_head;
    logic [PW-1:0] r_count, n_count;
    logic [PW-1:0] r_fill, n_fill;
    logic        r_strobe, n_strobe;

    // request and walk registers
    logic [1:0]            r_act, n_act;
    logic [DATA_WIDTH-1:0] r_key, n_key;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [PW-1:0]         r_cur, n_cur;
    logic [PW-1:0]         r_prev, n_prev;
    logic [PW-1:0]         r_steps, n_steps;
    logic [PW-1:0]         r_slot_link, n_slot_link;
    logic [DATA_WIDTH-1:0] r_res, n_res;
    logic                  r_found, n_found;
    logic                  r_full, n_full;

    // store ports
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [DATA_WIDTH-1:0] w_key_rdata;
    logic [DATA_WIDTH-1:0] w_val_rdata;
    logic [PW-1:0]         w_lnk_rdata;
    logic                  w_key_we;
    logic                  w_val_we;
    logic [AW-1:0]         w_kv_waddr;
    logic                  w_lnk_we;
    logic [AW-1:0]         w_lnk_waddr;
    logic [PW-1:0]         w_lnk_wdata;

    logic [XW-1:0]         w_key_x;
    logic [XW-1:0]         w_val_x;
    logic [XW-1:0]         w_res_x;
    logic [PW-1:0]         w_link;

    // input fields zero-extended or truncated to the data width
    assign w_key_x = XW'($unsigned(i_req.key));
    assign w_val_x = XW'($unsigned(i_req.value));

    // slots at or above the fill mark were never taken and still link to the next slot
    assign w_link = (r_cur < r_fill) ? w_lnk_rdata : (r_cur + PW'(1));

    // key store
    llkvm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_key_we),
        .i_wr_addr (w_kv_waddr),
        .i_wr_data (r_key),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_key_rdata)
    );

    // value store
    llkvm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_val_we),
        .i_wr_addr (w_kv_waddr),
        .i_wr_data (r_val),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_val_rdata)
    );

    // link store
    llkvm_ram #(
        .WIDTH (PW),
        .DEPTH (CAPACITY)
    ) u_lnk_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_lnk_we),
        .i_wr_addr (w_lnk_waddr),
        .i_wr_data (w_lnk_wdata),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_lnk_rdata)
    );

    // sequencer: walk, compare, unlink and insert
    always_comb begin
        n_state     = r_state;
        n_list_head = r_list_head;
        n_free_head = r_free_head;
        n_count     = r_count;
        n_fill      = r_fill;
        n_strobe    = 1'b0;
        n_act       = r_act;
        n_key       = r_key;
        n_val       = r_val;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_steps     = r_steps;
        n_slot_link = r_slot_link;
        n_res       = r_res;
        n_found     = r_found;
        n_full      = r_full;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_cur[AW-1:0];
        w_key_we    = 1'b0;
        w_val_we    = 1'b0;
        w_kv_waddr  = r_cur[AW-1:0];
        w_lnk_we    = 1'b0;
        w_lnk_waddr = r_cur[AW-1:0];
        w_lnk_wdata = r_free_head;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_act   = i_req.action;
                    n_key   = w_key_x[DATA_WIDTH-1:0];
                    n_val   = w_val_x[DATA_WIDTH-1:0];
                    n_prev  = NIL;
                    n_steps = '0;
                    n_cur   = r_list_head;
                    n_res   = '0;
                    n_found = 1'b0;
                    n_full  = 1'b0;
                    if (!(i_req.action inside {llkvm_pkg::ACT_ADD, llkvm_pkg::ACT_SEARCH,
                                               llkvm_pkg::ACT_REMOVE})) begin
                        // unused code: answer at once with the current count
                        n_strobe = 1'b1;
                    end else if (r_list_head < NIL) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_list_head[AW-1:0];
                        n_state   = S_CMP;
                    end else begin
                        n_state = S_MISS;
                    end
                end
            end

            S_CMP: begin
                if (w_key_rdata == r_key) begin
                    n_found     = 1'b1;
                    n_res       = w_val_rdata;
                    n_slot_link = w_link;
                    if (r_act == llkvm_pkg::ACT_REMOVE) begin
                        n_state = S_REM1;
                    end else begin
                        // replace the value in place on add
                        w_val_we = (r_act == llkvm_pkg::ACT_ADD);
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if ((w_link < NIL) && (r_steps < LAST_IDX)) begin
                    // follow the link straight from the read data
                    n_prev    = r_cur;
                    n_cur     = w_link;
                    n_steps   = r_steps + PW'(1);
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_link[AW-1:0];
                end else begin
                    n_state = S_MISS;
                end
            end

            S_REM1: begin
                // bypass the removed node
                if (r_prev < NIL) begin
                    w_lnk_we    = 1'b1;
                    w_lnk_waddr = r_prev[AW-1:0];
                    w_lnk_wdata = r_slot_link;
                end else begin
                    n_list_head = r_slot_link;
                end
                n_state = S_REM2;
            end

            S_REM2: begin
                // push the slot onto the free list
                w_lnk_we    = 1'b1;
                w_lnk_waddr = r_cur[AW-1:0];
                w_lnk_wdata = r_free_head;
                n_free_head = r_cur;
                if (r_count != '0) begin
                    n_count = r_count - PW'(1);
                end
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end

            S_MISS: begin
                if ((r_act == llkvm_pkg::ACT_ADD) && (r_free_head < NIL)) begin
                    // fetch the link of the first free slot
                    n_cur     = r_free_head;
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_free_head[AW-1:0];
                    n_state   = S_ALLOC;
                end else begin
                    n_full   = (r_act == llkvm_pkg::ACT_ADD);
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_ALLOC: begin
                // pop the free slot and link it in at the head
                n_free_head = w_link;
                w_key_we    = 1'b1;
                w_val_we    = 1'b1;
                w_lnk_we    = 1'b1;
                w_lnk_waddr = r_cur[AW-1:0];
                w_lnk_wdata = r_list_head;
                n_list_head = r_cur;
                n_count     = r_count + PW'(1);
                if (r_cur == r_fill) begin
                    n_fill = r_fill + PW'(1);
                end
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_list_head <= NIL;
            r_free_head <= '0;
            r_count     <= '0;
            r_fill      <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_list_head <= n_list_head;
            r_free_head <= n_free_head;
            r_count     <= n_count;
            r_fill      <= n_fill;
            r_strobe    <= n_strobe;
        end
    end

    // request, walk and result payload
    always_ff @(posedge i_clk) begin
        r_act       <= n_act;
        r_key       <= n_key;
        r_val       <= n_val;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_steps     <= n_steps;
        r_slot_link <= n_slot_link;
        r_res       <= n_res;
        r_found     <= n_found;
        r_full      <= n_full;
    end

    // result transaction
    assign w_res_x = XW'($signed(r_res));

    always_comb begin
        o_resp              = '0;
        o_resp.result_value = $signed(w_res_x[llkvm_pkg::FIELD_W-1:0]);
        o_resp.found        = r_found;
        o_resp.full_res     = r_full;
        o_resp.entry_count  = llkvm_pkg::COUNT_W'(r_count);
    end

    assign o_strobe = r_strobe;
    assign busy     = (r_state != S_IDLE);

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// tb: self-checking testbench for linked_list_key_value_map (add, search, remove on a keyed list)
// depends on llkvm_pkg and the block's rtl; a map model predicts each result not given in a row
module tb;

    localparam int         CAP            = 128;
    localparam logic [7:0] NIL            = 8'(CAP);
    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         POOL_N         = 192;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 200;

    typedef struct {
        llkvm_pkg::t_req  req;
        bit               has_exp;
        llkvm_pkg::t_resp exp;
    } t_row;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    llkvm_pkg::t_req  req         = '0;
    logic             busy;
    logic             strobe;
    llkvm_pkg::t_resp resp;

    // typed expectation travelling alongside the directed requests
    bit               row_has_exp = 1'b0;
    llkvm_pkg::t_resp row_exp     = '0;

    // local copy of the map
    logic [31:0] key_mem  [CAP];
    logic [31:0] val_mem  [CAP];
    logic [7:0]  link_mem [CAP];
    logic [7:0]  list_head_m;
    logic [7:0]  free_head_m;
    logic [7:0]  count_m;

    llkvm_pkg::t_resp resp_due_q[$];
    int               mismatch_cnt    = 0;
    int               stall_cycles    = 0;
    int               sender_idle_pct = 0;
    logic [31:0]      key_pool [POOL_N];
    t_row             dir_rows[$];

    wire took_req = start && !busy && i_rst_n;

    linked_list_key_value_map DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (req),
        .busy    (busy),
        .o_strobe(strobe),
        .o_resp  (resp)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // map model: empty list, every slot chained on the free list
    function automatic void map_clear();
        for (int i = 0; i < CAP; i++) begin
            key_mem[i]  = '0;
            val_mem[i]  = '0;
            link_mem[i] = 8'(i + 1);
        end
        list_head_m = NIL;
        free_head_m = '0;
        count_m     = '0;
    endfunction

    // apply one request to the map model and return the result it causes
    function automatic llkvm_pkg::t_resp map_apply(llkvm_pkg::t_req r);
        llkvm_pkg::t_resp res;
        logic [7:0]       cur;
        logic [7:0]       prev;
        logic [7:0]       hit;
        logic [7:0]       slot;
        int               steps;
        res   = '0;
        cur   = list_head_m;
        prev  = NIL;
        hit   = NIL;
        steps = 0;
        if (r.action == llkvm_pkg::ACT_ADD || r.action == llkvm_pkg::ACT_SEARCH ||
            r.action == llkvm_pkg::ACT_REMOVE) begin
            // bounded walk down the list for the key
            while (cur < NIL && steps < CAP && hit == NIL) begin
                if (key_mem[cur] == r.key) begin
                    hit = cur;
                end else begin
                    prev  = cur;
                    cur   = link_mem[cur];
                    steps = steps + 1;
                end
            end
            if (hit != NIL) begin
                res.found        = 1'b1;
                res.result_value = val_mem[hit];
                if (r.action == llkvm_pkg::ACT_ADD) begin
                    val_mem[hit] = r.value;
                end else if (r.action == llkvm_pkg::ACT_REMOVE) begin
                    // unlink, then push the slot onto the free list
                    if (prev != NIL) begin
                        link_mem[prev] = link_mem[hit];
                    end else begin
                        list_head_m = link_mem[hit];
                    end
                    link_mem[hit] = free_head_m;
                    free_head_m   = hit;
                    if (count_m != 0) begin
                        count_m = count_m - 1'b1;
                    end
                end
            end else if (r.action == llkvm_pkg::ACT_ADD) begin
                if (free_head_m >= NIL) begin
                    res.full_res = 1'b1;
                end else begin
                    // pop a free slot and link it in at the head
                    slot           = free_head_m;
                    free_head_m    = link_mem[slot];
                    key_mem[slot]  = r.key;
                    val_mem[slot]  = r.value;
                    link_mem[slot] = list_head_m;
                    list_head_m    = slot;
                    count_m        = count_m + 1'b1;
                end
            end
        end
        res.entry_count = count_m;
        return res;
    endfunction

    task automatic flag_mismatch(string what, llkvm_pkg::t_resp exp_r, llkvm_pkg::t_resp got_r);
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= 10) begin
            $display("mismatch (%s): expected value %h found %b full %b count %0d,",
                     what, exp_r.result_value, exp_r.found, exp_r.full_res, exp_r.entry_count);
            $display("    got value %h found %b full %b count %0d",
                     got_r.result_value, got_r.found, got_r.full_res, got_r.entry_count);
        end
    endtask

    // result checking and prediction on accepted transactions
    always @(posedge i_clk) begin
        llkvm_pkg::t_resp exp_r;
        llkvm_pkg::t_resp pred;
        if (!i_rst_n) begin
            map_clear();
            resp_due_q.delete();
        end else begin
            if (strobe) begin
                if (resp_due_q.size() == 0) begin
                    flag_mismatch("unexpected result", '0, resp);
                end else begin
                    exp_r = resp_due_q.pop_front();
                    if (resp.result_value !== exp_r.result_value || resp.found !== exp_r.found ||
                        resp.full_res !== exp_r.full_res ||
                        resp.entry_count !== exp_r.entry_count) begin
                        flag_mismatch("field", exp_r, resp);
                    end
                end
            end
            if (took_req) begin
                pred = map_apply(req);
                resp_due_q.push_back(row_has_exp ? row_exp : pred);
            end
        end
    end

    // watchdog on cycles with no transaction in either direction
    always @(posedge i_clk) begin
        if (took_req || (strobe === 1'b1)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // offer one request and hold it until taken, then maybe go idle
    task automatic send(llkvm_pkg::t_req r, bit has_exp, llkvm_pkg::t_resp exp_r);
        req         <= r;
        start       <= 1'b1;
        row_has_exp <= has_exp;
        row_exp     <= exp_r;
        do @(posedge i_clk); while (busy);
        if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 48)) @(posedge i_clk);
        end
    endtask

    // hold off until every owed result has come back
    task automatic wait_results();
        start <= 1'b0;
        while (resp_due_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_row mk_row(logic [1:0] a, logic [31:0] k, logic [31:0] v, bit chk,
                                    logic [31:0] rv, bit f, bit fl, logic [7:0] n);
        t_row row;
        row.req.action        = a;
        row.req.key           = k;
        row.req.value         = v;
        row.has_exp           = chk;
        row.exp.result_value  = rv;
        row.exp.found         = f;
        row.exp.full_res      = fl;
        row.exp.entry_count   = n;
        return row;
    endfunction

    // random traffic with a given mix of actions and key spread
    task automatic run_phase(int n, int p_add, int p_search, int p_remove, int span, int idle);
        llkvm_pkg::t_req r;
        int              pick;
        sender_idle_pct = idle;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < p_add) begin
                r.action = llkvm_pkg::ACT_ADD;
            end else if (pick < p_add + p_search) begin
                r.action = llkvm_pkg::ACT_SEARCH;
            end else if (pick < p_add + p_search + p_remove) begin
                r.action = llkvm_pkg::ACT_REMOVE;
            end else begin
                r.action = ACT_UNUSED;
            end
            r.key   = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, span - 1)];
            r.value = $urandom;
            send(r, 1'b0, '0);
        end
        wait_results();
    endtask

    initial begin
        llkvm_pkg::t_req r;
        // key pool with the extremes up front
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_N; i++) begin
            key_pool[i] = $urandom;
        end

        // directed: empty map, extremes, replace, unlink in middle and at tail, unused code
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_SEARCH, 32'h0000_0000, 32'h0000_0000,
                                  1, 32'h0, 0, 0, 0));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_REMOVE, 32'h7fff_ffff, 32'h0000_0000,
                                  1, 32'h0, 0, 0, 0));
        dir_rows.push_back(mk_row(ACT_UNUSED, 32'hffff_ffff, 32'hffff_ffff,
                                  1, 32'h0, 0, 0, 0));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_ADD, 32'h8000_0000, 32'h7fff_ffff,
                                  1, 32'h0, 0, 0, 1));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_ADD, 32'h7fff_ffff, 32'h8000_0000,
                                  1, 32'h0, 0, 0, 2));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_SEARCH, 32'h8000_0000, 32'h0,
                                  1, 32'h7fff_ffff, 1, 0, 2));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_ADD, 32'h8000_0000, 32'h0,
                                  1, 32'h7fff_ffff, 1, 0, 2));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_SEARCH, 32'h7fff_ffff, 32'h0,
                                  1, 32'h8000_0000, 1, 0, 2));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_REMOVE, 32'h8000_0000, 32'h0,
                                  1, 32'h0, 1, 0, 1));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_REMOVE, 32'h8000_0000, 32'h0,
                                  1, 32'h0, 0, 0, 1));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_ADD, 32'h0000_0000, 32'hffff_ffff,
                                  1, 32'h0, 0, 0, 2));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_SEARCH, 32'h0000_0000, 32'h1234_5678,
                                  1, 32'hffff_ffff, 1, 0, 2));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_REMOVE, 32'h7fff_ffff, 32'h0,
                                  1, 32'h8000_0000, 1, 0, 1));
        dir_rows.push_back(mk_row(ACT_UNUSED, 32'h0000_0000, 32'h0000_0000,
                                  1, 32'h0, 0, 0, 1));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_ADD, 32'h0000_0001, 32'h0000_0005,
                                  1, 32'h0, 0, 0, 2));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_ADD, 32'h0000_0002, 32'h0000_0006,
                                  1, 32'h0, 0, 0, 3));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_ADD, 32'h0000_0003, 32'h0000_0007,
                                  1, 32'h0, 0, 0, 4));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_REMOVE, 32'h0000_0002, 32'h0,
                                  1, 32'h0000_0006, 1, 0, 3));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_REMOVE, 32'h0000_0000, 32'h0,
                                  1, 32'hffff_ffff, 1, 0, 2));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_SEARCH, 32'h0000_0001, 32'h0,
                                  0, 32'h0, 0, 0, 0));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_ADD, 32'h0000_0004, 32'h0000_0008,
                                  0, 32'h0, 0, 0, 0));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_REMOVE, 32'h0000_0003, 32'h0,
                                  0, 32'h0, 0, 0, 0));
        dir_rows.push_back(mk_row(llkvm_pkg::ACT_SEARCH, 32'h0000_0002, 32'h0,
                                  0, 32'h0, 0, 0, 0));

        // synchronous reset
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].exp);
        end
        wait_results();

        // fill sweep past capacity so adds of new keys run into a full map
        for (int i = 0; i < CAP + 4; i++) begin
            r.action = llkvm_pkg::ACT_ADD;
            r.key    = key_pool[i];
            r.value  = $urandom;
            send(r, 1'b0, '0);
        end
        wait_results();

        // random phases: mostly add, balanced with idling, drain, balanced with light idling
        run_phase(340, 90, 5, 3, POOL_N, 0);
        run_phase(340, 40, 30, 28, 64, 58);
        run_phase(340, 15, 25, 58, POOL_N, 0);
        run_phase(340, 45, 25, 28, 160, 9);

        start <= 1'b0;
        while (resp_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && resp_due_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
